// ===== hw/rtl/tmph_pkg.sv =====
// ----------------------------------------------------------------------------
// tmph_pkg
// Shared widths and register indexes of the trimmed-mean pH meter.
// ----------------------------------------------------------------------------
package tmph_pkg;

    localparam int SAMPLE_W = 10;   // converter sample width
    localparam int SLOPE_W  = 10;   // slope register width
    localparam int OFFSET_W = 8;    // signed offset register width
    localparam int SUM_W    = 16;   // window sum and trimmed sum width
    localparam int PH_W     = 8;    // pH in tenths, one byte
    localparam int CFG_W    = 10;   // configuration data width
    localparam int CFG_IDX_W = 2;   // configuration index width

    // slope * trimmed sum, then times five, plus headroom for the divider.
    localparam int MUL_W = SLOPE_W + SUM_W;
    localparam int REM_W = MUL_W + 4;

    // Quotient bits kept by the divider; larger quotients saturate.
    localparam int QUOT_W = 9;

    // Converter full scale times ten, one factor of the divisor. It is five
    // times two to the power DEN_SHIFT, so the divisor always ends in
    // DEN_SHIFT zero bits.
    localparam int DEN_UNIT  = 10240;
    localparam int DEN_SHIFT = 11;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int PH_MAX     = (1 << PH_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);

    localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(350);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

endpackage

// ===== hw/rtl/tmph_div.sv =====
// ----------------------------------------------------------------------------
// tmph_div
// Divider by a constant through reciprocal multiplication, saturating; the
// product is registered first, then the saturated quotient.
// ----------------------------------------------------------------------------
module tmph_div
    import tmph_pkg::*;
#(
    parameter int DIVISOR = 389120
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [REM_W-1:0]  i_dividend,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    // The low DEN_SHIFT zero bits of the divisor come off the dividend as a
    // shift. The remaining factor is divided by a multiplication with its
    // rounded-up reciprocal, which is exact for every shifted dividend of
    // YW bits because the rounding error stays below one step of the shift.
    localparam int     YW     = REM_W - DEN_SHIFT;
    localparam int     DIV_LO = DIVISOR >> DEN_SHIFT;
    localparam int     DW     = $clog2(DIV_LO + 1);
    localparam int     RSH    = YW + DW;
    localparam longint RECIP  = ((longint'(1) << RSH) + longint'(DIV_LO) - 1)
                              / longint'(DIV_LO);
    localparam int     MW     = $clog2(RECIP + 1);
    localparam int     PW     = YW + MW;
    localparam int     QW     = PW - RSH;
    localparam logic [MW-1:0] RECIP_V = MW'(RECIP);
    localparam logic [QW-1:0] Q_MAX   = QW'((1 << QUOT_W) - 1);

    logic              r_busy;
    logic              r_done;
    logic [PW-1:0]     r_prod;
    logic [QUOT_W-1:0] r_quot;
    logic [YW-1:0]     y;
    logic [QW-1:0]     q_full;

    assign y      = i_dividend[REM_W-1:DEN_SHIFT];
    assign q_full = r_prod[PW-1:RSH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= y * RECIP_V;
        end
        if (r_busy) begin
            r_quot <= (q_full > Q_MAX) ? '1 : q_full[QUOT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hw/rtl/trimmed_mean_ph_meter.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_ph_meter
// Sliding-window trimmed-mean filter for a pH probe converter, scaled to pH
// in tenths.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Word
//  --------  ---------  -------------------------  ---------------------------
//  adc       in         i_adc_valid / o_adc_ready  adc_sample
//  ph        out        o_ph_valid  / i_ph_ready   ph_tenths, trimmed_sum
//  cfg       in         i_cfg_we (no wait)         index i_cfg_idx, data
//
// Each word runs from acceptance to the result register through one pass over
// the window memory, one read per cycle, then trim, multiply, scale, and a
// divide by reciprocal multiplication. The next word can be accepted in the
// cycle after the previous result is written to the output register.
// A new word is accepted once the previous one has moved to the output
// register; a result waiting there does not hold off the next sample until
// that next result is ready to be written.
// Reset is synchronous, active low; the window reads as zeros after reset
// through per-entry valid bits, so no clearing pass is needed.

module trimmed_mean_ph_meter
    import tmph_pkg::*;
#(
    parameter int WINDOW_SIZE = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_adc_valid,
    output logic                 o_adc_ready,
    input  logic [SAMPLE_W-1:0]  i_adc_sample,

    output logic                 o_ph_valid,
    input  logic                 i_ph_ready,
    output logic [PH_W-1:0]      o_ph_tenths,
    output logic [SUM_W-1:0]     o_trimmed_sum,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int DEN = DEN_UNIT * (WINDOW_SIZE - 2);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_SIZE - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_TRIM  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]            r_state;

    // Configuration registers.
    logic [SLOPE_W-1:0]    r_slope;
    logic [OFFSET_W-1:0]   r_offset;

    // Window memory with a valid bit per entry; an entry never written
    // reads as zero, which matches the all-zero window after reset.
    logic [SAMPLE_W-1:0]   r_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] r_valid;
    logic [AW-1:0]         r_wr_pos;
    logic [AW-1:0]         r_addr;
    logic [SAMPLE_W-1:0]   r_rd_data;
    logic                  r_rd_vld;
    logic                  r_rd_en;

    // Window statistics.
    logic [SUM_W-1:0]      r_total;
    logic [SAMPLE_W-1:0]   r_lo;
    logic [SAMPLE_W-1:0]   r_hi;
    logic [SUM_W-1:0]      r_trim;
    logic [MUL_W-1:0]      r_prod;

    // Output register.
    logic                  r_out_valid;
    logic [PH_W-1:0]       r_ph;
    logic [SUM_W-1:0]      r_trim_out;

    logic                  accept;
    logic                  out_free;
    logic [SAMPLE_W-1:0]   rd_val;
    logic                  div_start;
    logic [REM_W-1:0]      scaled;
    logic                  div_done;
    logic [QUOT_W-1:0]     quot;
    logic signed [QUOT_W+1:0] ph_raw;
    logic [PH_W-1:0]       ph_sat;

    assign accept    = i_adc_valid && o_adc_ready;
    assign out_free  = !r_out_valid || i_ph_ready;
    assign rd_val    = r_rd_vld ? r_rd_data : '0;
    assign div_start = (r_state == S_SCALE);

    // slope * trimmed * 5 as a shift and add.
    assign scaled = REM_W'({r_prod, 2'b00}) + REM_W'(r_prod);

    // Integer part of the scaled mean plus the signed offset, then clamp.
    assign ph_raw = $signed({2'b00, quot})
                  + (QUOT_W+2)'($signed(r_offset));

    always_comb begin
        if (ph_raw < 0) begin
            ph_sat = '0;
        end else if (ph_raw > (QUOT_W+2)'(PH_MAX)) begin
            ph_sat = PH_W'(PH_MAX);
        end else begin
            ph_sat = ph_raw[PH_W-1:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= SLOPE_RESET;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SLOPE:  r_slope  <= i_cfg_data[SLOPE_W-1:0];
                REG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Window memory: the new sample is written on acceptance, and the
    // sweep reads one entry per cycle starting the cycle after.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wr_pos] <= i_adc_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_addr];
        r_rd_vld  <= r_valid[r_addr];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_wr_pos    <= '0;
            r_addr      <= '0;
            r_rd_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A finished word enters the output register when it is empty or as the
            // previous one leaves it.
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ph_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_valid[r_wr_pos] <= 1'b1;
                        r_wr_pos <= (r_wr_pos == LAST_ADDR) ? '0 : r_wr_pos + 1'b1;
                        r_addr   <= '0;
                        r_state  <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_rd_en <= 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_LAST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_LAST: begin
                    r_rd_en <= 1'b0;
                    r_state <= S_TRIM;
                end
                S_TRIM:  r_state <= S_MUL;
                S_MUL:   r_state <= S_SCALE;
                S_SCALE: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: running sum, minimum and maximum over the window pass,
    // then trimming, the slope product and the capture of the result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_total <= '0;
            r_lo    <= SAMPLE_W'(SAMPLE_MAX);
            r_hi    <= '0;
        end else if (r_rd_en) begin
            r_total <= r_total + SUM_W'(rd_val);
            if (rd_val < r_lo) begin
                r_lo <= rd_val;
            end
            if (rd_val > r_hi) begin
                r_hi <= rd_val;
            end
        end

        if (r_state == S_TRIM) begin
            r_trim <= r_total - SUM_W'(r_lo) - SUM_W'(r_hi);
        end
        if (r_state == S_MUL) begin
            r_prod <= r_slope * r_trim;
        end
        if (r_state == S_FIN && out_free) begin
            r_ph       <= ph_sat;
            r_trim_out <= r_trim;
        end
    end

    tmph_div #(
        .DIVISOR (DEN)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (scaled),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign o_adc_ready   = (r_state == S_IDLE);
    assign o_ph_valid    = r_out_valid;
    assign o_ph_tenths   = r_ph;
    assign o_trimmed_sum = r_trim_out;

endmodule
